// ===== rtl/keyed_record_table_unit_defines.svh =====
// Assertion macros for the keyed record table.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/krt_pkg.sv =====
// Package for the keyed record table: sizes, codes, beat and record types.
// No dependencies.
`timescale 1ns / 1ps

package krt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = 5;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_DELETE = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_LIST   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_SHIFT,
        S_LIST
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [31:0] key_id;
        logic [31:0] year_in;
        logic [31:0] course1_id_in;
        logic [31:0] course1_grade_in;
        logic [31:0] course2_id_in;
        logic [31:0] course2_grade_in;
        logic [31:0] course3_id_in;
        logic [31:0] course3_grade_in;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] used_count;
        logic [31:0]      rec_key;
        logic [31:0]      rec_year;
        logic [31:0]      rec_course1_id;
        logic [31:0]      rec_course1_grade;
        logic [31:0]      rec_course2_id;
        logic [31:0]      rec_course2_grade;
        logic [31:0]      rec_course3_id;
        logic [31:0]      rec_course3_grade;
        logic             last;
    } t_out_item;

    // One table row as held in the memory.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] year;
        logic [31:0] c1_id;
        logic [31:0] c1_grade;
        logic [31:0] c2_id;
        logic [31:0] c2_grade;
        logic [31:0] c3_id;
        logic [31:0] c3_grade;
    } t_rec;

endpackage

// ===== rtl/keyed_record_table_unit.sv =====
// Keyed record table, 16 rows in one memory (registered read), packed in order.
// Add appends at the tail; lookup and delete scan rows from 0 and compare each read key;
// delete then moves every later row up by one. A miss ends the scan after row count-1.
// List: key beats one per cycle, one per row; an empty list gives a single miss beat.
// Sequential: busy drops with the last beat, so the next accept can share its edge.
// Sync reset clears count, FSM and strobe; rows hold no reset value and need no clear pass.
`timescale 1ns / 1ps

`include "keyed_record_table_unit_defines.svh"

module keyed_record_table_unit
    import krt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_item
);

    // Row storage
    t_rec             r_mem [TABLE_DEPTH];
    t_rec             r_rdata;

    // Control
    t_state           r_state;
    t_state           n_state;
    t_in_item         r_cmd;
    t_in_item         n_cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    // Read pointer runs 0..count, so it is count-wide; memory index is its low bits.
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] n_ptr;
    // A read has landed: while r_pend is set, r_rdata holds row r_pend_idx.
    logic             r_pend;
    logic             n_pend;
    logic [CNT_W-1:0] r_pend_idx;
    logic [CNT_W-1:0] n_pend_idx;

    // Result register
    logic             r_strobe;
    logic             n_strobe;
    t_out_item        r_out;
    t_out_item        n_out;

    // Memory port controls
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_rec             w_wr_data;

    logic             w_hit;
    logic             w_more;
    logic             w_list_last;
    logic [CNT_W-1:0] w_shift_dst;
    t_rec             w_new_rec;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_item   = r_out;

    assign w_hit       = r_pend && (r_rdata.key == r_cmd.key_id);
    assign w_more      = (r_ptr < r_count);
    assign w_list_last = (r_pend_idx == (r_count - CNT_W'(1)));
    assign w_shift_dst = r_pend_idx - CNT_W'(1);
    assign w_rd_addr   = r_ptr[IDX_W-1:0];

    assign w_new_rec.key      = r_cmd.key_id;
    assign w_new_rec.year     = r_cmd.year_in;
    assign w_new_rec.c1_id    = r_cmd.course1_id_in;
    assign w_new_rec.c1_grade = r_cmd.course1_grade_in;
    assign w_new_rec.c2_id    = r_cmd.course2_id_in;
    assign w_new_rec.c2_grade = r_cmd.course2_grade_in;
    assign w_new_rec.c3_id    = r_cmd.course3_id_in;
    assign w_new_rec.c3_grade = r_cmd.course3_grade_in;

    // ---------------------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.func)
                    FN_ADD: begin
                        n_state = S_IDLE;
                    end
                    FN_DELETE, FN_LOOKUP: begin
                        n_state = S_SEARCH;
                    end
                    FN_LIST: begin
                        n_state = (r_count == '0) ? S_IDLE : S_LIST;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_state = (r_cmd.func == FN_DELETE) ? S_SHIFT : S_IDLE;
                end else if (!w_more) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!w_more && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (r_pend && w_list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Datapath and result beats
    // ---------------------------------------------------------------------------------
    always_comb begin
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_pend     = 1'b0;
        n_pend_idx = r_ptr;
        n_strobe   = 1'b0;
        n_out      = '0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_count[IDX_W-1:0];
        w_wr_data  = w_new_rec;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_item;
                end
            end
            S_EXEC: begin
                n_ptr = '0;
                case (r_cmd.func)
                    FN_ADD: begin
                        n_strobe = 1'b1;
                        n_out.last = 1'b1;
                        if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            // append at the tail
                            w_wr_en      = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_out.status = ST_OK;
                        end
                    end
                    FN_LIST: begin
                        if (r_count == '0) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_MISS;
                            n_out.last   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SEARCH: begin
                // Reads issue every cycle until a hit or the last row; compare uses the registered read.
                if (w_hit) begin
                    if (r_cmd.func == FN_LOOKUP) begin
                        n_strobe                = 1'b1;
                        n_out.status            = ST_OK;
                        n_out.last              = 1'b1;
                        n_out.rec_key           = r_rdata.key;
                        n_out.rec_year          = r_rdata.year;
                        n_out.rec_course1_id    = r_rdata.c1_id;
                        n_out.rec_course1_grade = r_rdata.c1_grade;
                        n_out.rec_course2_id    = r_rdata.c2_id;
                        n_out.rec_course2_grade = r_rdata.c2_grade;
                        n_out.rec_course3_id    = r_rdata.c3_id;
                        n_out.rec_course3_grade = r_rdata.c3_grade;
                    end else begin
                        n_ptr = r_pend_idx + CNT_W'(1);
                    end
                end else if (w_more) begin
                    w_rd_en    = 1'b1;
                    n_ptr      = r_ptr + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr;
                end else begin
                    n_strobe     = 1'b1;
                    n_out.status = ST_MISS;
                    n_out.last   = 1'b1;
                end
            end
            S_SHIFT: begin
                // Row i+1 read, then written to row i: read and write never meet.
                if (r_pend) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_shift_dst[IDX_W-1:0];
                    w_wr_data = r_rdata;
                end
                if (w_more) begin
                    w_rd_en    = 1'b1;
                    n_ptr      = r_ptr + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr;
                end else if (!r_pend) begin
                    n_count      = r_count - CNT_W'(1);
                    n_strobe     = 1'b1;
                    n_out.status = ST_OK;
                    n_out.last   = 1'b1;
                end
            end
            S_LIST: begin
                if (r_pend) begin
                    n_strobe      = 1'b1;
                    n_out.status  = ST_OK;
                    n_out.rec_key = r_rdata.key;
                    n_out.last    = w_list_last;
                end
                if (w_more) begin
                    w_rd_en    = 1'b1;
                    n_ptr      = r_ptr + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr;
                end
            end
            default: begin
            end
        endcase

        n_out.used_count = n_count;
    end

    // ---------------------------------------------------------------------------------
    // Row memory: one write and one registered read per cycle
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // ---------------------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ptr      <= n_ptr;
        r_pend_idx <= n_pend_idx;
        r_out      <= n_out;
    end

    // ---------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------
    `KRT_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "count beyond depth")
    `KRT_ASSERT_NOW(a_last_leaves_idle, o_strobe && o_item.last, !busy, "busy after last beat")
    `KRT_ASSERT_NOW(a_mid_beat_is_list, o_strobe && !o_item.last, r_state == S_LIST, "non-last beat outside list")
    `KRT_ASSERT_NOW(a_shift_no_clash, w_rd_en && w_wr_en, w_rd_addr != w_wr_addr, "read and write hit one row")

endmodule
